FILE: sv/saa_pkg.sv
// Shared constants, op codes and controller/datapath handshake structs
// for the generation-stamped set-all array. No dependencies.
package saa_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int STAMP_BITS_DEF = 8;

  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  localparam int IN_TDATA_W  = 48;  // op + index + value = 44, padded to bytes
  localparam int OUT_TDATA_W = 40;  // read_value + from_default = 33, padded

  localparam logic [OP_W-1:0] OP_SET = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_ALL = 2'd2;

  typedef struct packed {
    logic wr_en;     // write one entry
    logic rd_en;     // read one entry into the lookup registers
    logic set_all;   // load default, advance generation
    logic clr_en;    // clear one stamp in the sweep
    logic load_out;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep is at its last entry
    logic gen_wrap;  // next generation would wrap to zero
  } sts_t;

endpackage

FILE: sv/saa_ctrl.sv
// Sequencer for the set-all array: stamp clearing sweep, idle, lookup.
// Depends on saa_pkg for op codes and the command/status structs.
module saa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [saa_pkg::OP_W-1:0]   op,
  input  logic                       out_tready,
  input  saa_pkg::sts_t              sts,
  output logic                       in_tready,
  output logic                       out_tvalid,
  output saa_pkg::cmd_t              cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    cmd          = '0;
    cmd.wr_en    = acc && (op == saa_pkg::OP_SET);
    cmd.rd_en    = acc && (op == saa_pkg::OP_GET);
    cmd.set_all  = acc && (op == saa_pkg::OP_ALL);
    cmd.clr_en   = (state_r == ST_CLEAR);
    cmd.load_out = (state_r == ST_LOOK) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.rd_en) state_nxt = ST_LOOK;
        else if (cmd.set_all && sts.gen_wrap) state_nxt = ST_CLEAR;
      end
      ST_LOOK: begin
        if (cmd.load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/saa_dpath.sv
// Datapath for the set-all array: value and stamp memories, generation,
// default, clearing counter and result register. Depends on saa_pkg.
module saa_dpath #(
  parameter int DEPTH      = saa_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = saa_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  saa_pkg::cmd_t                     cmd,
  input  logic [saa_pkg::IDX_W-1:0]         in_index,
  input  logic signed [saa_pkg::VAL_W-1:0]  in_value,
  output saa_pkg::sts_t                     sts,
  output logic signed [saa_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_from_default
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [saa_pkg::VAL_W-1:0] value_mem [DEPTH];
  logic [STAMP_BITS-1:0]            stamp_mem [DEPTH];

  logic [STAMP_BITS-1:0]            gen_r, gen_nxt, gen_inc;
  logic signed [saa_pkg::VAL_W-1:0] dflt_r;
  logic [AW-1:0]                    clr_cnt_r, clr_cnt_nxt;
  logic signed [saa_pkg::VAL_W-1:0] rd_val_r;
  logic [STAMP_BITS-1:0]            rd_stamp_r;
  logic                             rd_ok_r;
  logic signed [saa_pkg::VAL_W-1:0] out_val_r;
  logic                             out_fd_r;

  logic [AW-1:0] addr;
  logic          in_range;
  logic          hit;

  assign addr     = AW'(in_index);
  assign in_range = (32'(in_index) < DEPTH);

  assign gen_inc      = gen_r + 1'b1;
  assign sts.gen_wrap = (gen_inc == '0);
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.set_all) gen_nxt = sts.gen_wrap ? STAMP_BITS'(1) : gen_inc;
  end

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_en) clr_cnt_nxt = sts.clr_last ? '0 : clr_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= STAMP_BITS'(1);
      dflt_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      gen_r     <= gen_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cmd.set_all) dflt_r <= in_value;
    end
  end

  // sweep and entry writes never overlap: the sweep runs only while no item is taken
  always_ff @(posedge clk) begin
    if (cmd.clr_en) stamp_mem[clr_cnt_r] <= '0;
    else if (cmd.wr_en && in_range) stamp_mem[addr] <= gen_r;
    if (cmd.wr_en && in_range) value_mem[addr] <= in_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_val_r   <= value_mem[addr];
      rd_stamp_r <= stamp_mem[addr];
      rd_ok_r    <= in_range;
    end
  end

  assign hit = rd_ok_r && (rd_stamp_r == gen_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_val_r <= hit ? rd_val_r : dflt_r;
      out_fd_r  <= !hit;
    end
  end

  assign out_read_value   = out_val_r;
  assign out_from_default = out_fd_r;

endmodule

FILE: sv/set_all_array_unit.sv
// Set-all array top level. Set and set-all may follow back to back; a get
// reads the memories at the accepting edge, then loads the result register
// once out_tvalid is low or out_tready is high, and only then frees the input.
// After reset, and after a set-all that wraps the generation, a stamp clearing
// sweep over all DEPTH entries runs, one stamp per cycle, with in_tready low.
// Depends on saa_pkg, saa_ctrl and saa_dpath.
module set_all_array_unit #(
  parameter int DEPTH      = saa_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = saa_pkg::STAMP_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [saa_pkg::IN_TDATA_W-1:0]     in_tdata,   // op[1:0], index[11:2], value[43:12]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [saa_pkg::OUT_TDATA_W-1:0]    out_tdata   // read_value[31:0], from_default[32]
);

  localparam int OP_LO  = 0;
  localparam int IDX_LO = OP_LO + saa_pkg::OP_W;
  localparam int VAL_LO = IDX_LO + saa_pkg::IDX_W;
  localparam int PAD_W  = saa_pkg::OUT_TDATA_W - saa_pkg::VAL_W - 1;

  logic [saa_pkg::OP_W-1:0]         in_op;
  logic [saa_pkg::IDX_W-1:0]        in_index;
  logic signed [saa_pkg::VAL_W-1:0] in_value;
  logic signed [saa_pkg::VAL_W-1:0] out_read_value;
  logic                             out_from_default;

  saa_pkg::cmd_t cmd;
  saa_pkg::sts_t sts;

  assign in_op    = in_tdata[IDX_LO-1:OP_LO];
  assign in_index = in_tdata[VAL_LO-1:IDX_LO];
  assign in_value = in_tdata[VAL_LO+saa_pkg::VAL_W-1:VAL_LO];

  assign out_tdata = {{PAD_W{1'b0}}, out_from_default, out_read_value};

  saa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .op         (in_op),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  saa_dpath #(
    .DEPTH      (DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_index         (in_index),
    .in_value         (in_value),
    .sts              (sts),
    .out_read_value   (out_read_value),
    .out_from_default (out_from_default)
  );

  // a get holds off the input until its result is loaded
  a_get_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> !in_tready)
    else $error("input ready right after a get transfer");

  // a wrapping set-all starts the clearing sweep
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.set_all && sts.gen_wrap) |=> (cmd.clr_en && !in_tready))
    else $error("generation wrap did not start stamp clearing");

  // a new result only follows a lookup cycle
  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(cmd.load_out) && !$past(in_tready)))
    else $error("result appeared without a lookup");

  // sweep and entry traffic never coincide
  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !(cmd.wr_en || cmd.rd_en || cmd.set_all))
    else $error("item transfer during stamp clearing");

endmodule
